>>> hw/rtl/dual_axis_light_tracker_control_macros.svh
// Assertion helpers for the light tracker checker.
`ifndef DUAL_AXIS_LIGHT_TRACKER_CONTROL_MACROS_SVH
`define DUAL_AXIS_LIGHT_TRACKER_CONTROL_MACROS_SVH

// Property checked on every clock edge outside reset.
`define DALTC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define DALTC_ASSERT_IMP(name, ante, cons, msg) \
    `DALTC_ASSERT(name, (ante) |-> (cons), msg)

// Next-cycle implication.
`define DALTC_ASSERT_NEXT(name, ante, cons, msg) \
    `DALTC_ASSERT(name, (ante) |=> (cons), msg)

`endif

>>> hw/rtl/daltc_pkg.sv
`default_nettype none

package daltc_pkg;

    localparam int LEVEL_W = 10;
    localparam int AZ_W    = 12;
    localparam int LIM_W   = 11;
    localparam int ELEV_W  = 8;
    localparam int CMD_W   = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 11;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    typedef logic [1:0] cmp_t;
    localparam cmp_t CMP_EQUAL   = 2'd0;
    localparam cmp_t CMP_BIGGER  = 2'd1;
    localparam cmp_t CMP_SMALLER = 2'd2;

    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_HOLD  = 2'd0;
    localparam cmd_t CMD_STOP  = 2'd1;
    localparam cmd_t CMD_LEFT  = 2'd2;
    localparam cmd_t CMD_RIGHT = 2'd3;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
    localparam cfg_addr_t REG_START_THRESHOLD  = 3'd0;
    localparam cfg_addr_t REG_STOP_THRESHOLD   = 3'd1;
    localparam cfg_addr_t REG_AZIMUTH_LIMIT    = 3'd2;
    localparam cfg_addr_t REG_ELEVATION_TOP    = 3'd3;
    localparam cfg_addr_t REG_ELEVATION_BOTTOM = 3'd4;
    localparam cfg_addr_t REG_LIMIT_ENABLE     = 3'd5;

    localparam logic [LEVEL_W-1:0] START_THRESHOLD_RST  = 10'd20;
    localparam logic [LEVEL_W-1:0] STOP_THRESHOLD_RST   = 10'd5;
    localparam logic [LIM_W-1:0]   AZIMUTH_LIMIT_RST    = 11'd1024;
    localparam logic [ELEV_W-1:0]  ELEVATION_TOP_RST    = 8'd180;
    localparam logic [ELEV_W-1:0]  ELEVATION_BOTTOM_RST = 8'd0;

    typedef struct packed {
        logic [LEVEL_W-1:0] start_threshold;
        logic [LEVEL_W-1:0] stop_threshold;
        logic [LIM_W-1:0]   azimuth_limit;
        logic [ELEV_W-1:0]  elevation_top;
        logic [ELEV_W-1:0]  elevation_bottom;
        logic               limit_enable;
    } cfg_t;

    typedef struct packed {
        logic              tracking_horizontal;
        logic              tracking_vertical;
        logic              unwinding;
        logic [ELEV_W-1:0] elevation_pos;
    } state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]     left_level;
        logic [LEVEL_W-1:0]     right_level;
        logic [LEVEL_W-1:0]     up_level;
        logic [LEVEL_W-1:0]     down_level;
        logic signed [AZ_W-1:0] azimuth_pos;
    } sample_t;

    typedef struct packed {
        cmd_t              azimuth_command;
        logic [ELEV_W-1:0] elevation_out;
        logic              elevation_moved;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/dual_axis_light_tracker_control.sv
`default_nettype none

// Dual-axis light tracker controller.
// Input stream (s_*): one transfer per sample of four light sensors plus the
// current azimuth position. Output stream (m_*): one transfer per sample with
// the azimuth motor command, the new elevation and an elevation-moved flag.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata write one register per cycle;
// write only while no sample is in flight.
// A result passes the input register, then the result register, before it
// is offered. Throughput: one sample per cycle while the output is not stalled; the
// tracking state feeds back through the step logic into the state register.
// s_tready stays high while the input register is empty or can move on, so a
// new sample is taken even while a result waits on m_tready. When the output
// stalls, the result and one queued sample hold, and s_tready drops.
// Reset clears all tracking flags, puts elevation at the reset value of the
// bottom limit and loads the register defaults; a later bottom-limit write
// does not move the elevation.
module dual_axis_light_tracker_control
    import daltc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // left_level[9:0], right_level[19:10], up_level[29:20], down_level[39:30],
    // azimuth_pos[51:40], zero pad
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // azimuth_command[1:0], elevation_out[9:2], elevation_moved[10], zero pad
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg;
    sample_t sample_reg;
    logic    in_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    result_t result_reg;
    logic    out_valid_reg;
    logic    advance;

    daltc_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .cfg      (cfg)
    );

    daltc_step u_step (
        .cfg       (cfg),
        .state     (state_reg),
        .sample    (sample_reg),
        .state_next(state_next),
        .result    (result_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.tracking_horizontal <= 1'b0;
            state_reg.tracking_vertical   <= 1'b0;
            state_reg.unwinding           <= 1'b0;
            state_reg.elevation_pos       <= ELEVATION_BOTTOM_RST;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            sample_reg.left_level  <= s_tdata[9:0];
            sample_reg.right_level <= s_tdata[19:10];
            sample_reg.up_level    <= s_tdata[29:20];
            sample_reg.down_level  <= s_tdata[39:30];
            sample_reg.azimuth_pos <= s_tdata[51:40];
        end
        if (advance)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, result_reg.elevation_moved, result_reg.elevation_out,
                       result_reg.azimuth_command};

endmodule

`default_nettype wire

>>> hw/rtl/daltc_pair_cmp.sv
`default_nettype none

// Hysteresis pair compare: equal when |a-b| <= band, else bigger or smaller.
module daltc_pair_cmp
    import daltc_pkg::*;
(
    input  wire logic [LEVEL_W-1:0] a,
    input  wire logic [LEVEL_W-1:0] b,
    input  wire logic [LEVEL_W-1:0] band,
    output cmp_t                    result
);

    logic [LEVEL_W:0]   diff;
    logic [LEVEL_W-1:0] diff_mag;

    always_comb
    begin
        diff     = {1'b0, a} - {1'b0, b};
        diff_mag = diff[LEVEL_W] ? LEVEL_W'(~diff + 1'b1) : diff[LEVEL_W-1:0];
        if (diff_mag <= band)
            result = CMP_EQUAL;
        else if (a > b)
            result = CMP_BIGGER;
        else
            result = CMP_SMALLER;
    end

endmodule

`default_nettype wire

>>> hw/rtl/daltc_step.sv
`default_nettype none

// One tracking step: next state and result from the current state and a sample.
module daltc_step
    import daltc_pkg::*;
(
    input  wire cfg_t    cfg,
    input  wire state_t  state,
    input  wire sample_t sample,
    output state_t       state_next,
    output result_t      result
);

    cmp_t lr_start;
    cmp_t lr_stop;
    cmp_t ud_start;
    cmp_t ud_stop;

    daltc_pair_cmp u_lr_start (
        .a(sample.left_level), .b(sample.right_level),
        .band(cfg.start_threshold), .result(lr_start)
    );
    daltc_pair_cmp u_lr_stop (
        .a(sample.left_level), .b(sample.right_level),
        .band(cfg.stop_threshold), .result(lr_stop)
    );
    daltc_pair_cmp u_ud_start (
        .a(sample.up_level), .b(sample.down_level),
        .band(cfg.start_threshold), .result(ud_start)
    );
    daltc_pair_cmp u_ud_stop (
        .a(sample.up_level), .b(sample.down_level),
        .band(cfg.stop_threshold), .result(ud_stop)
    );

    logic               run_h;
    logic               run_v;
    logic               zenith;
    logic               unwind_act;
    logic [AZ_W-1:0]    az_mag;
    logic signed [AZ_W:0] az_plus;
    logic signed [AZ_W:0] az_minus;
    logic [AZ_W:0]      plus_mag;
    logic [AZ_W:0]      minus_mag;
    cmd_t               cmd;

    always_comb
    begin
        az_mag    = sample.azimuth_pos[AZ_W-1] ? AZ_W'(~sample.azimuth_pos + 1'b1)
                                               : sample.azimuth_pos;
        az_plus   = {sample.azimuth_pos[AZ_W-1], sample.azimuth_pos}
                  + $signed({2'b00, cfg.azimuth_limit});
        az_minus  = {sample.azimuth_pos[AZ_W-1], sample.azimuth_pos}
                  - $signed({2'b00, cfg.azimuth_limit});
        plus_mag  = az_plus[AZ_W] ? (AZ_W+1)'(-az_plus) : az_plus;
        minus_mag = az_minus[AZ_W] ? (AZ_W+1)'(-az_minus) : az_minus;

        state_next = state;
        cmd        = CMD_HOLD;

        // horizontal tracking
        run_h  = (state.tracking_horizontal || (lr_start != CMP_EQUAL)) && !state.unwinding;
        // at the top with only vertical tracking: swing azimuth toward the nearer limit
        zenith = !run_h && state.tracking_vertical && !state.tracking_horizontal
              && (state.elevation_pos == cfg.elevation_top);
        if (run_h)
        begin
            state_next.tracking_horizontal = (lr_stop != CMP_EQUAL);
            case (lr_stop)
                CMP_EQUAL:  cmd = CMD_STOP;
                CMP_BIGGER: cmd = CMD_LEFT;
                default:    cmd = CMD_RIGHT;
            endcase
        end
        else if (zenith)
        begin
            cmd = (plus_mag < minus_mag) ? CMD_LEFT : CMD_RIGHT;
        end

        // azimuth limit unwind
        unwind_act = (state.unwinding || (az_mag > {1'b0, cfg.azimuth_limit}))
                  && cfg.limit_enable;
        if (unwind_act)
        begin
            if (!state.unwinding)
            begin
                state_next.unwinding = 1'b1;
                cmd = (sample.azimuth_pos > 0) ? CMD_RIGHT : CMD_LEFT;
            end
            if (lr_stop == CMP_EQUAL)
            begin
                state_next.unwinding = 1'b0;
                cmd = CMD_STOP;
            end
        end

        // vertical tracking
        run_v = state.tracking_vertical || (ud_start != CMP_EQUAL);
        if (run_v)
        begin
            state_next.tracking_vertical = (ud_stop != CMP_EQUAL);
            case (ud_stop)
                CMP_BIGGER:
                begin
                    if (state.elevation_pos < cfg.elevation_top)
                        state_next.elevation_pos = state.elevation_pos + 1'b1;
                end
                CMP_SMALLER:
                begin
                    if (state.elevation_pos > cfg.elevation_bottom)
                        state_next.elevation_pos = state.elevation_pos - 1'b1;
                end
                default: ;
            endcase
        end

        result.azimuth_command = cmd;
        result.elevation_out   = state_next.elevation_pos;
        result.elevation_moved = (state_next.elevation_pos != state.elevation_pos);
    end

endmodule

`default_nettype wire

>>> hw/rtl/daltc_cfg_regs.sv
`default_nettype none

// Configuration register file, write only.
module daltc_cfg_regs
    import daltc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_START_THRESHOLD:  cfg_next.start_threshold  = cfg_wdata[LEVEL_W-1:0];
                REG_STOP_THRESHOLD:   cfg_next.stop_threshold   = cfg_wdata[LEVEL_W-1:0];
                REG_AZIMUTH_LIMIT:    cfg_next.azimuth_limit    = cfg_wdata[LIM_W-1:0];
                REG_ELEVATION_TOP:    cfg_next.elevation_top    = cfg_wdata[ELEV_W-1:0];
                REG_ELEVATION_BOTTOM: cfg_next.elevation_bottom = cfg_wdata[ELEV_W-1:0];
                REG_LIMIT_ENABLE:     cfg_next.limit_enable     = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_threshold  <= START_THRESHOLD_RST;
            cfg_reg.stop_threshold   <= STOP_THRESHOLD_RST;
            cfg_reg.azimuth_limit    <= AZIMUTH_LIMIT_RST;
            cfg_reg.elevation_top    <= ELEVATION_TOP_RST;
            cfg_reg.elevation_bottom <= ELEVATION_BOTTOM_RST;
            cfg_reg.limit_enable     <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dual_axis_light_tracker_control_checker.sv
`default_nettype none
`include "dual_axis_light_tracker_control_macros.svh"

module dual_axis_light_tracker_control_checker
    import daltc_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);

    logic [ELEV_W-1:0] last_elev_reg;
    logic [ELEV_W-1:0] last_elev_next;
    logic [ELEV_W-1:0] out_elev;
    logic              out_moved;
    logic              out_xfer;
    logic              out_stall;
    logic              elev_same;
    logic              elev_step;

    assign out_xfer       = m_tvalid && m_tready;
    assign out_stall      = m_tvalid && !m_tready;
    assign out_elev       = m_tdata[9:2];
    assign out_moved      = m_tdata[10];
    assign last_elev_next = out_xfer ? out_elev : last_elev_reg;
    assign elev_same      = (out_elev == last_elev_reg);
    assign elev_step      = (out_elev == last_elev_reg + 8'd1)
                         || (out_elev == last_elev_reg - 8'd1);

    // elevation seen on the last output transfer; starts at the reset bottom limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_elev_reg <= ELEVATION_BOTTOM_RST;
        else
            last_elev_reg <= last_elev_next;
    end

    `DALTC_ASSERT_IMP(a_ready_when_out_empty, !m_tvalid, s_tready, "input stalled, output empty")
    `DALTC_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "held result changed")
    `DALTC_ASSERT_IMP(a_elev_still, out_xfer && !out_moved, elev_same, "unflagged elevation move")
    `DALTC_ASSERT_IMP(a_elev_step, out_xfer && out_moved, elev_step, "elevation jumped")
    `DALTC_ASSERT_IMP(a_out_pad, m_tvalid, m_tdata[15:11] == 5'd0, "output pad bits not zero")

endmodule

bind dual_axis_light_tracker_control dual_axis_light_tracker_control_checker u_checker (.*);

`default_nettype wire

>>> verif/dual_axis_light_tracker_control_tb.sv
`timescale 1ns / 1ps

module dual_axis_light_tracker_control_tb;
    import daltc_pkg::*;

    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int LONG_HOLD = 40;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // left_level[9:0], right_level[19:10], up_level[29:20], down_level[39:30],
    // azimuth_pos[51:40], zero pad
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // azimuth_command[1:0], elevation_out[9:2], elevation_moved[10], zero pad
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    dual_axis_light_tracker_control dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    typedef struct {
        sample_t s;
        bit      typed;
        result_t want;
    } vector_t;

    // tracker model state and register copy
    cfg_t              cur_cfg;
    logic              trk_h;
    logic              trk_v;
    logic              unwind;
    logic [ELEV_W-1:0] elev_pos;

    result_t   pending_results[$];
    vector_t   plan[$];
    cfg_t      phase_cfg[PHASES];
    bit        burst = 1'b0;
    int        sent = 0;
    int        rx_count = 0;
    int        failures = 0;
    int        stall_left = 0;
    int        moved_count = 0;
    int        cmd_seen[4] = '{0, 0, 0, 0};
    result_t   got;
    result_t   want;

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic cmp_t compare_pair(input int a, input int b, input int band);
        if (magnitude(a - b) <= band)
            return CMP_EQUAL;
        if (a > b)
            return CMP_BIGGER;
        return CMP_SMALLER;
    endfunction

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int near(input int base, input int spread);
        return clamp(base + $urandom_range(0, 2 * spread) - spread, 0, 1023);
    endfunction

    function automatic cfg_t settings(input int st, input int sp, input int lim,
                                      input int top, input int bot, input bit en);
        cfg_t c;
        c.start_threshold  = LEVEL_W'(st);
        c.stop_threshold   = LEVEL_W'(sp);
        c.azimuth_limit    = LIM_W'(lim);
        c.elevation_top    = ELEV_W'(top);
        c.elevation_bottom = ELEV_W'(bot);
        c.limit_enable     = en;
        return c;
    endfunction

    // One sample through the tracker: horizontal, zenith, unwind, vertical.
    task automatic track_step(input sample_t s, output result_t r);
        int                az;
        int                lim;
        int                l;
        int                rt;
        int                u;
        int                dn;
        cmd_t              cmd;
        logic [ELEV_W-1:0] prior;
        az    = s.azimuth_pos;
        lim   = cur_cfg.azimuth_limit;
        l     = s.left_level;
        rt    = s.right_level;
        u     = s.up_level;
        dn    = s.down_level;
        cmd   = CMD_HOLD;
        prior = elev_pos;

        if ((trk_h || compare_pair(l, rt, cur_cfg.start_threshold) != CMP_EQUAL)
            && !unwind)
        begin
            trk_h = 1'b1;
            case (compare_pair(l, rt, cur_cfg.stop_threshold))
                CMP_EQUAL:
                begin
                    cmd   = CMD_STOP;
                    trk_h = 1'b0;
                end
                CMP_BIGGER: cmd = CMD_LEFT;
                default:    cmd = CMD_RIGHT;
            endcase
        end
        else if (trk_v && !trk_h && elev_pos == cur_cfg.elevation_top)
        begin
            // at the zenith, swing toward the nearer azimuth end
            cmd = (magnitude(az + lim) < magnitude(az - lim)) ? CMD_LEFT : CMD_RIGHT;
        end

        if ((unwind || magnitude(az) > lim) && cur_cfg.limit_enable)
        begin
            if (!unwind)
            begin
                unwind = 1'b1;
                cmd = (az > 0) ? CMD_RIGHT : CMD_LEFT;
            end
            if (compare_pair(l, rt, cur_cfg.stop_threshold) == CMP_EQUAL)
            begin
                cmd    = CMD_STOP;
                unwind = 1'b0;
            end
        end

        if (trk_v || compare_pair(u, dn, cur_cfg.start_threshold) != CMP_EQUAL)
        begin
            trk_v = 1'b1;
            case (compare_pair(u, dn, cur_cfg.stop_threshold))
                CMP_EQUAL: trk_v = 1'b0;
                CMP_BIGGER:
                    if (elev_pos < cur_cfg.elevation_top)
                        elev_pos = elev_pos + 1'b1;
                default:
                    if (elev_pos > cur_cfg.elevation_bottom)
                        elev_pos = elev_pos - 1'b1;
            endcase
        end

        r.azimuth_command = cmd;
        r.elevation_out   = elev_pos;
        r.elevation_moved = (elev_pos != prior);
    endtask

    task automatic add_row(input int l, input int rt, input int u, input int dn,
                           input int az, input bit typed, input cmd_t cmd,
                           input int elev, input bit moved);
        vector_t v;
        v.s.left_level  = LEVEL_W'(l);
        v.s.right_level = LEVEL_W'(rt);
        v.s.up_level    = LEVEL_W'(u);
        v.s.down_level  = LEVEL_W'(dn);
        v.s.azimuth_pos = AZ_W'(az);
        v.typed         = typed;
        v.want.azimuth_command = cmd;
        v.want.elevation_out   = ELEV_W'(elev);
        v.want.elevation_moved = moved;
        plan.push_back(v);
    endtask

    function automatic sample_t draw_sample();
        sample_t s;
        int      spread;
        int      base;
        int      lim;
        if ($urandom_range(0, 4) == 0)
        begin
            s.left_level  = LEVEL_W'($urandom_range(0, 1023));
            s.right_level = LEVEL_W'($urandom_range(0, 1023));
            s.up_level    = LEVEL_W'($urandom_range(0, 1023));
            s.down_level  = LEVEL_W'($urandom_range(0, 1023));
            s.azimuth_pos = AZ_W'($urandom_range(0, 4095));
            return s;
        end
        // readings that hover around the start and stop bands
        spread = $urandom_range(0, 1) ? int'(cur_cfg.start_threshold) + 8 : 12;
        spread = clamp(spread, 1, 1023);
        base = $urandom_range(0, 1023);
        s.left_level  = LEVEL_W'(near(base, spread));
        s.right_level = LEVEL_W'(near(base, spread));
        base = $urandom_range(0, 1023);
        s.up_level    = LEVEL_W'(near(base, spread));
        s.down_level  = LEVEL_W'(near(base, spread));
        lim = cur_cfg.azimuth_limit;
        case ($urandom_range(0, 3))
            0: s.azimuth_pos = AZ_W'($urandom_range(0, 4095));
            1: s.azimuth_pos = AZ_W'(clamp(lim + $urandom_range(0, 6) - 3, -2048, 2047));
            2: s.azimuth_pos = AZ_W'(clamp(-lim + $urandom_range(0, 6) - 3, -2048, 2047));
            default: s.azimuth_pos = AZ_W'($urandom_range(0, 64) - 32);
        endcase
        return s;
    endfunction

    task automatic reg_write(input cfg_addr_t addr, input int value);
        cfg_addr  <= addr;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t c);
        cfg_wr_en <= 1'b1;
        reg_write(REG_START_THRESHOLD, c.start_threshold);
        reg_write(REG_STOP_THRESHOLD, c.stop_threshold);
        reg_write(REG_AZIMUTH_LIMIT, c.azimuth_limit);
        reg_write(REG_ELEVATION_TOP, c.elevation_top);
        reg_write(REG_ELEVATION_BOTTOM, c.elevation_bottom);
        reg_write(REG_LIMIT_ENABLE, c.limit_enable);
        cfg_wr_en <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic send_sample(input sample_t s, input bit typed, input result_t fixed);
        int      gap;
        result_t r;
        gap = burst ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, s.azimuth_pos, s.down_level, s.up_level,
                     s.right_level, s.left_level};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_step(s, r);
        pending_results.push_back(typed ? fixed : r);
        sent++;
    endtask

    // two-stage pipeline; a few spare cycles cover it
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // result side: random stalls, bursts of full rate, two long hold-offs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.azimuth_command = m_tdata[1:0];
                got.elevation_out   = m_tdata[9:2];
                got.elevation_moved = m_tdata[10];
                rx_count++;
                cmd_seen[got.azimuth_command]++;
                if (got.elevation_moved)
                    moved_count++;
                if (pending_results.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result: cmd %0d elev %0d moved %0d",
                                 got.azimuth_command, got.elevation_out,
                                 got.elevation_moved);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.azimuth_command !== want.azimuth_command
                        || got.elevation_out !== want.elevation_out
                        || got.elevation_moved !== want.elevation_moved)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("result %0d: cmd %0d/%0d elev %0d/%0d moved %0d/%0d (exp/act)",
                                     rx_count, want.azimuth_command, got.azimuth_command,
                                     want.elevation_out, got.elevation_out,
                                     want.elevation_moved, got.elevation_moved);
                    end
                end
                stall_left = ((rx_count / 40) % 4 == 0) ? 0 : $urandom_range(0, 3);
                if (rx_count == 250 || rx_count == 650)
                    stall_left = LONG_HOLD;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            m_tready <= (stall_left == 0);
        end
    end

    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        result_t none;
        none = '0;

        cur_cfg.start_threshold  = START_THRESHOLD_RST;
        cur_cfg.stop_threshold   = STOP_THRESHOLD_RST;
        cur_cfg.azimuth_limit    = AZIMUTH_LIMIT_RST;
        cur_cfg.elevation_top    = ELEVATION_TOP_RST;
        cur_cfg.elevation_bottom = ELEVATION_BOTTOM_RST;
        cur_cfg.limit_enable     = 1'b1;
        trk_h    = 1'b0;
        trk_v    = 1'b0;
        unwind   = 1'b0;
        elev_pos = ELEVATION_BOTTOM_RST;

        //      left  right  up    down  az     typed cmd        elev moved
        add_row(0,    0,     0,    0,    0,     1,    CMD_HOLD,  0,   0);
        add_row(1023, 0,     0,    0,    0,     1,    CMD_LEFT,  0,   0);
        add_row(0,    1023,  0,    0,    0,     1,    CMD_RIGHT, 0,   0);
        add_row(512,  512,   0,    0,    0,     1,    CMD_STOP,  0,   0);
        add_row(0,    0,     1023, 0,    0,     1,    CMD_HOLD,  1,   1);
        add_row(0,    0,     0,    1023, 0,     1,    CMD_HOLD,  0,   1);
        add_row(0,    0,     0,    1023, 0,     1,    CMD_HOLD,  0,   0);
        add_row(0,    0,     0,    0,    0,     1,    CMD_HOLD,  0,   0);
        add_row(0,    0,     0,    0,    2047,  1,    CMD_STOP,  0,   0);
        add_row(100,  0,     0,    0,    -2048, 1,    CMD_LEFT,  0,   0);
        // unwind in progress blocks horizontal tracking, then ends in band
        add_row(100,  0,     0,    0,    0,     0,    CMD_HOLD,  0,   0);
        add_row(3,    0,     0,    0,    0,     0,    CMD_HOLD,  0,   0);
        add_row(0,    0,     0,    0,    0,     0,    CMD_HOLD,  0,   0);
        add_row(0,    0,     0,    0,    1024,  0,    CMD_HOLD,  0,   0);
        add_row(0,    0,     0,    0,    1025,  0,    CMD_HOLD,  0,   0);
        add_row(0,    0,     0,    0,    -1025, 0,    CMD_HOLD,  0,   0);
        add_row(1023, 1023,  1023, 1023, -1,    0,    CMD_HOLD,  0,   0);
        // hysteresis edges at the default bands
        add_row(0,    21,    30,   0,    0,     0,    CMD_HOLD,  0,   0);
        add_row(0,    20,    6,    0,    0,     0,    CMD_HOLD,  0,   0);
        add_row(0,    5,     5,    0,    0,     0,    CMD_HOLD,  0,   0);
        add_row(0,    20,    20,   0,    0,     0,    CMD_HOLD,  0,   0);
        add_row(682,  341,   341,  682,  -1366, 0,    CMD_HOLD,  0,   0);

        //                        start stop  limit top  bottom enable
        phase_cfg[0] = settings(20,   5,    1024,  180, 0,   1'b1);
        phase_cfg[1] = settings(0,    0,    0,     255, 0,   1'b1);
        phase_cfg[2] = settings(1023, 1023, 2047,  255, 255, 1'b0);
        phase_cfg[3] = settings(8,    3,    600,   4,   0,   1'b1);
        phase_cfg[4] = settings(5,    30,   300,   20,  2,   1'b1);
        phase_cfg[5] = settings(40,   10,   900,   10,  50,  1'b1);
        phase_cfg[6] = settings(15,   4,    500,   6,   1,   1'b0);
        phase_cfg[7] = settings(10,   2,    1023,  3,   0,   1'b1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_sample(plan[i].s, plan[i].typed, plan[i].want);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            load_settings(phase_cfg[p]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                burst = ((k / 24) % 4 == 1);
                if (p == 1 && k == 60)
                    drain();
                send_sample(draw_sample(), 1'b0, none);
            end
            drain();
        end

        $display("summary: %0d samples over %0d register settings, %0d results checked",
                 sent, PHASES + 1, rx_count);
        $display("summary: hold %0d, stop %0d, left %0d, right %0d, elevation moves %0d",
                 cmd_seen[CMD_HOLD], cmd_seen[CMD_STOP], cmd_seen[CMD_LEFT],
                 cmd_seen[CMD_RIGHT], moved_count);
        if (failures == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
